/* design/ipe_pkg.sv */
package ipe_pkg;

    localparam int MODE_W   = 3;
    localparam int DATA16_W = 16;
    localparam int DATA8_W  = 8;

    localparam logic [MODE_W-1:0] MODE_WRITE16 = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE8  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ16  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ8   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SWITCH  = 3'd4;

    localparam int OE_BIT     = 0;
    localparam int SWITCH_BIT = 9;

    localparam logic [DATA16_W-1:0] OE_MASK     = 16'h0001;
    localparam logic [DATA16_W-1:0] SWITCH_MASK = 16'h0200;

    function automatic logic [DATA16_W-1:0] interlock16(input logic [DATA16_W-1:0] v);
        logic [DATA16_W-1:0] r;
        r = v;
        if (v[OE_BIT])
        begin
            r = v & OE_MASK;
        end
        r = r & ~SWITCH_MASK;
        return r;
    endfunction

endpackage

/* design/i2c_port_expander_emulator.sv */
// Transaction-level emulation of a 16-bit and an 8-bit I2C port expander.
// The input channel (in_valid, in_ready) carries one item per completed bus
// transaction or switch-pin change: mode, write_value and switch_level.
// The output channel (out_valid, out_ready) returns one result item for every
// input item: read_data, pins16, pins8 and the active-low int_line.
// An accepted item is held in an input register and is processed from there
// into the result register, which presents its result; while a stalled result
// occupies the result register, the item waits in the input register.
// One item is accepted every cycle while the output side keeps up; the only
// stage between the two registers is a little masking and selection logic.
// When the receiver stalls, the result is held and the input register keeps
// one further item, so in_ready falls only once both stages are occupied.
// pins16, pins8 and int_line are driven straight from the expander state,
// which changes only when a new result is loaded, so they always agree with
// the result item on offer.
// Reset clears both expander states, the remembered switch levels and the
// interrupt latch, releasing int_line, and empties both stages.
module i2c_port_expander_emulator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ipe_pkg::MODE_W-1:0]    mode,
    input  logic [ipe_pkg::DATA16_W-1:0]  write_value,
    input  logic                          switch_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ipe_pkg::DATA16_W-1:0]  read_data,
    output logic [ipe_pkg::DATA16_W-1:0]  pins16,
    output logic [ipe_pkg::DATA8_W-1:0]   pins8,
    output logic                          int_line
);
    import ipe_pkg::*;

    logic                 inp_valid_reg;
    logic [MODE_W-1:0]    inp_mode_reg;
    logic [DATA16_W-1:0]  inp_wv_reg;
    logic                 inp_lvl_reg;

    logic                 res_valid_reg;
    logic [DATA16_W-1:0]  read_data_reg;
    logic [DATA16_W-1:0]  read_data_next;

    logic [DATA16_W-1:0]  state16_reg;
    logic [DATA16_W-1:0]  state16_next;
    logic [DATA8_W-1:0]   state8_reg;
    logic [DATA8_W-1:0]   state8_next;
    logic                 last_level_reg;
    logic                 last_level_next;
    logic                 return_level_reg;
    logic                 return_level_next;
    logic                 int_latched_reg;
    logic                 int_latched_next;

    logic advance;
    logic fire;
    logic in_take;

    assign advance = !res_valid_reg || out_ready;
    assign fire    = inp_valid_reg && advance;
    assign in_ready = !inp_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        state16_next      = state16_reg;
        state8_next       = state8_reg;
        last_level_next   = last_level_reg;
        return_level_next = return_level_reg;
        int_latched_next  = int_latched_reg;
        read_data_next    = '0;
        case (inp_mode_reg)
            MODE_WRITE16:
            begin
                int_latched_next = 1'b0;
                state16_next     = interlock16(inp_wv_reg);
            end
            MODE_WRITE8:
            begin
                state8_next = inp_wv_reg[DATA8_W-1:0];
            end
            MODE_READ16:
            begin
                int_latched_next         = 1'b0;
                state16_next[SWITCH_BIT] = inp_lvl_reg;
                read_data_next           = state16_next;
            end
            MODE_READ8:
            begin
                read_data_next = {{(DATA16_W-DATA8_W){1'b0}}, state8_reg};
            end
            MODE_SWITCH:
            begin
                if (inp_lvl_reg != last_level_reg)
                begin
                    if (!int_latched_reg)
                    begin
                        return_level_next = last_level_reg;
                        int_latched_next  = 1'b1;
                    end
                    else if (inp_lvl_reg == return_level_reg)
                    begin
                        int_latched_next = 1'b0;
                    end
                    last_level_next = inp_lvl_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inp_valid_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
            state16_reg      <= '0;
            state8_reg       <= '0;
            last_level_reg   <= 1'b0;
            return_level_reg <= 1'b0;
            int_latched_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                inp_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= inp_valid_reg;
            end
            if (fire)
            begin
                state16_reg      <= state16_next;
                state8_reg       <= state8_next;
                last_level_reg   <= last_level_next;
                return_level_reg <= return_level_next;
                int_latched_reg  <= int_latched_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            inp_mode_reg <= mode;
            inp_wv_reg   <= write_value;
            inp_lvl_reg  <= switch_level;
        end
        if (fire)
        begin
            read_data_reg <= read_data_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign read_data = read_data_reg;
    assign pins16    = state16_reg;
    assign pins8     = state8_reg;
    assign int_line  = !int_latched_reg;

`ifndef SYNTHESIS
    a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        state16_reg[OE_BIT] |-> ((state16_reg & ~(OE_MASK | SWITCH_MASK)) == '0))
        else $error("interlock violated on 16-bit expander state");

    a_switch_bit_only_on_read16: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && inp_mode_reg != MODE_READ16 && inp_mode_reg != MODE_WRITE16)
        |=> $stable(state16_reg))
        else $error("16-bit state changed without a 16-bit access");

    a_access16_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (inp_mode_reg == MODE_WRITE16 || inp_mode_reg == MODE_READ16))
        |=> int_line)
        else $error("interrupt not released by 16-bit access");

    a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_ready) |=> ($stable(state16_reg) && $stable(state8_reg)
        && $stable(int_latched_reg)))
        else $error("expander state changed while a result was stalled");
`endif

endmodule

/* tb/i2c_port_expander_emulator_test.sv */
`timescale 1ns / 100ps

module i2c_port_expander_emulator_test;

    import ipe_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed
    {
        logic [MODE_W-1:0]   mode;
        logic [DATA16_W-1:0] value;
        logic                level;
    } transfer_t;

    typedef struct packed
    {
        logic [DATA16_W-1:0] read_data;
        logic [DATA16_W-1:0] pins16;
        logic [DATA8_W-1:0]  pins8;
        logic                int_line;
    } expander_view_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [MODE_W-1:0]   mode = MODE_WRITE16;
    logic [DATA16_W-1:0] write_value = '0;
    logic                switch_level = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [DATA16_W-1:0] read_data;
    logic [DATA16_W-1:0] pins16;
    logic [DATA8_W-1:0]  pins8;
    logic                int_line;

    transfer_t      pending_transfers[$];
    expander_view_t awaited_views[$];

    logic [DATA16_W-1:0] port16_state = '0;
    logic [DATA8_W-1:0]  port8_state = '0;
    logic                switch_seen = 1'b0;
    logic                switch_home = 1'b0;
    logic                irq_latched = 1'b0;

    int  send_gap = 0;
    int  take_gap = 0;
    int  cycle_count = 0;
    bit  failed = 1'b0;

    i2c_port_expander_emulator u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .write_value  (write_value),
        .switch_level (switch_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .pins16       (pins16),
        .pins8        (pins8),
        .int_line     (int_line)
    );

    always #5 clk = ~clk;

    function automatic expander_view_t expander_after(transfer_t t);
        expander_view_t      v;
        logic [DATA16_W-1:0] w;
        v.read_data = '0;
        case (t.mode)
            MODE_WRITE16:
            begin
                irq_latched = 1'b0;
                w = t.value;
                if (w[OE_BIT])
                begin
                    w = w & OE_MASK;
                end
                w[SWITCH_BIT] = 1'b0;
                port16_state = w;
            end
            MODE_WRITE8:
            begin
                port8_state = t.value[DATA8_W-1:0];
            end
            MODE_READ16:
            begin
                irq_latched = 1'b0;
                port16_state[SWITCH_BIT] = t.level;
                v.read_data = port16_state;
            end
            MODE_READ8:
            begin
                v.read_data = {{(DATA16_W-DATA8_W){1'b0}}, port8_state};
            end
            MODE_SWITCH:
            begin
                if (t.level != switch_seen)
                begin
                    if (!irq_latched)
                    begin
                        switch_home = switch_seen;
                        irq_latched = 1'b1;
                    end
                    else if (t.level == switch_home)
                    begin
                        irq_latched = 1'b0;
                    end
                    switch_seen = t.level;
                end
            end
            default:
            begin
            end
        endcase
        v.pins16 = port16_state;
        v.pins8 = port8_state;
        v.int_line = ~irq_latched;
        return v;
    endfunction

    task automatic queue_transfer(input logic [MODE_W-1:0] m, input logic [DATA16_W-1:0] value,
                                  input logic level);
        transfer_t t;
        t.mode = m;
        t.value = value;
        t.level = level;
        pending_transfers.push_back(t);
    endtask

    always @(posedge clk)
    begin
        transfer_t t;
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (in_valid)
                begin
                    t.mode = mode;
                    t.value = write_value;
                    t.level = switch_level;
                    awaited_views.push_back(expander_after(t));
                end
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_transfers.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (pending_transfers.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end
                else
                begin
                    t = pending_transfers.pop_front();
                    in_valid <= 1'b1;
                    mode <= t.mode;
                    write_value <= t.value;
                    switch_level <= t.level;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        expander_view_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_views.size() == 0)
                begin
                    $display("%0t: unexpected item: read_data %h pins16 %h pins8 %h int_line %b",
                             $time, read_data, pins16, pins8, int_line);
                    failed = 1'b1;
                end
                else
                begin
                    e = awaited_views.pop_front();
                    if (read_data !== e.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h", $time, e.read_data,
                                 read_data);
                        failed = 1'b1;
                    end
                    if (pins16 !== e.pins16)
                    begin
                        $display("%0t: pins16 expected %h actual %h", $time, e.pins16, pins16);
                        failed = 1'b1;
                    end
                    if (pins8 !== e.pins8)
                    begin
                        $display("%0t: pins8 expected %h actual %h", $time, e.pins8, pins8);
                        failed = 1'b1;
                    end
                    if (int_line !== e.int_line)
                    begin
                        $display("%0t: int_line expected %b actual %b", $time, e.int_line,
                                 int_line);
                        failed = 1'b1;
                    end
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                out_ready <= 1'b0;
            end
            else if (pending_transfers.size() > CALM_ITEMS && $urandom_range(0, 9) == 0)
            begin
                take_gap = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("i2c_port_expander_emulator regression: fail");
            $finish;
        end
    end

    initial
    begin
        logic [DATA16_W-1:0] value;
        int                  pick;

        queue_transfer(MODE_WRITE16, 16'hFFFF, 1'b0);
        queue_transfer(MODE_WRITE16, 16'hFFFE, 1'b1);
        queue_transfer(MODE_READ16, 16'h0000, 1'b1);
        queue_transfer(MODE_READ16, 16'hFFFF, 1'b0);
        queue_transfer(MODE_WRITE16, 16'h0200, 1'b1);
        queue_transfer(MODE_WRITE16, 16'h0000, 1'b0);
        queue_transfer(MODE_WRITE8, 16'hFFFF, 1'b0);
        queue_transfer(MODE_READ8, 16'hFFFF, 1'b1);
        queue_transfer(MODE_WRITE8, 16'hAB00, 1'b1);
        queue_transfer(MODE_READ8, 16'h0000, 1'b0);
        queue_transfer(MODE_WRITE8, 16'h00A5, 1'b0);
        queue_transfer(MODE_SWITCH, 16'hFFFF, 1'b0);
        queue_transfer(MODE_SWITCH, 16'h0000, 1'b1);
        queue_transfer(MODE_READ8, 16'h0000, 1'b0);
        queue_transfer(MODE_SWITCH, 16'h1234, 1'b0);
        queue_transfer(MODE_SWITCH, 16'h0000, 1'b1);
        queue_transfer(MODE_WRITE8, 16'h005A, 1'b0);
        queue_transfer(MODE_READ16, 16'h0000, 1'b1);
        queue_transfer(MODE_SWITCH, 16'h0000, 1'b0);
        queue_transfer(MODE_SWITCH, 16'h0000, 1'b1);
        queue_transfer(MODE_SWITCH + 3'd1, 16'hFFFF, 1'b1);
        queue_transfer(MODE_SWITCH + 3'd2, 16'hFFFF, 1'b0);
        queue_transfer(MODE_SWITCH + 3'd3, 16'hFFFF, 1'b1);
        queue_transfer(MODE_READ16, 16'hFFFF, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            value = 16'($urandom);
            if ($urandom_range(0, 1) == 0)
            begin
                value[OE_BIT] = 1'b0;
            end
            pick = $urandom_range(0, 19);
            if (pick < 4)
            begin
                queue_transfer(MODE_WRITE16, value, 1'($urandom_range(0, 1)));
            end
            else if (pick < 7)
            begin
                queue_transfer(MODE_WRITE8, value, 1'($urandom_range(0, 1)));
            end
            else if (pick < 10)
            begin
                queue_transfer(MODE_READ16, value, 1'($urandom_range(0, 1)));
            end
            else if (pick < 12)
            begin
                queue_transfer(MODE_READ8, value, 1'($urandom_range(0, 1)));
            end
            else if (pick < 18)
            begin
                queue_transfer(MODE_SWITCH, value, 1'($urandom_range(0, 1)));
            end
            else
            begin
                queue_transfer(MODE_SWITCH + 3'($urandom_range(1, 3)), value,
                               1'($urandom_range(0, 1)));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_transfers.size() != 0 || in_valid || awaited_views.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(posedge clk);

        if (!failed && awaited_views.size() == 0)
        begin
            $display("i2c_port_expander_emulator regression: pass");
        end
        else
        begin
            $display("i2c_port_expander_emulator regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
design/ipe_pkg.sv
design/i2c_port_expander_emulator.sv
tb/i2c_port_expander_emulator_test.sv
